// ===== hdl/ddo_pkg.sv =====
`timescale 1ns / 1ps
package ddo_pkg;
  localparam int COUNT_WIDTH_DEF  = 12;
  localparam int CORDIC_STEPS_DEF = 20;
  localparam int ATAN_ENTRIES     = 30;
  localparam logic [24:0] FULL_TURN = 25'd23592960;
  localparam logic [33:0] INV_GAIN_Q30 = 34'sd652032874;
  localparam logic [0:0] REG_PULSE_DISTANCE = 1'b0;
  localparam logic [0:0] REG_TURN_GAIN      = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ANGLE, ST_CORDIC, ST_PROD, ST_WRAP, ST_DONE
  } state_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = 32'd536870912;  5'd1: atan_lut = 32'd316933406;
      5'd2: atan_lut = 32'd167458907;  5'd3: atan_lut = 32'd85004756;
      5'd4: atan_lut = 32'd42667331;   5'd5: atan_lut = 32'd21354465;
      5'd6: atan_lut = 32'd10679838;   5'd7: atan_lut = 32'd5340245;
      5'd8: atan_lut = 32'd2670163;    5'd9: atan_lut = 32'd1335087;
      5'd10: atan_lut = 32'd667544;    5'd11: atan_lut = 32'd333772;
      5'd12: atan_lut = 32'd166886;    5'd13: atan_lut = 32'd83443;
      5'd14: atan_lut = 32'd41722;     5'd15: atan_lut = 32'd20861;
      5'd16: atan_lut = 32'd10430;     5'd17: atan_lut = 32'd5215;
      5'd18: atan_lut = 32'd2608;      5'd19: atan_lut = 32'd1304;
      5'd20: atan_lut = 32'd652;       5'd21: atan_lut = 32'd326;
      5'd22: atan_lut = 32'd163;       5'd23: atan_lut = 32'd81;
      5'd24: atan_lut = 32'd41;        5'd25: atan_lut = 32'd20;
      5'd26: atan_lut = 32'd10;        5'd27: atan_lut = 32'd5;
      5'd28: atan_lut = 32'd3;         5'd29: atan_lut = 32'd1;
      default: atan_lut = 32'd0;
    endcase
  endfunction
endpackage

// ===== hdl/ddo_serial_mul.sv =====
`timescale 1ns / 1ps
// Unsigned shift-add multiplier, one multiplier bit per cycle.
module ddo_serial_mul import ddo_pkg::*; #(
  parameter int AW = 40,
  parameter int BW = 34
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic            done,
  output logic [AW+BW-1:0] prod
);
  localparam int CW = $clog2(BW + 1);
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [BW-1:0]    bsh;
  logic [AW+BW-1:0] ash;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(BW);
        bsh  <= b;
        ash  <= {{BW{1'b0}}, a};
        prod <= '0;
      end else if (busy) begin
        if (bsh[0]) prod <= prod + ash;
        ash <= ash << 1;
        bsh <= bsh >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hdl/differential_drive_odometry.sv =====
`timescale 1ns / 1ps
// Dead-reckoning odometry for a two-wheel base.
// Input channel (in_valid/in_stall): cmd, left/right counts and directions.
// Output channel (out_valid/out_stall): pos_x, pos_y, heading after the sample.
// One result per transfer. One item is worked at a time, and the input stalls
// until the result has been taken.
// An update runs five shift-add products (two wheel distances, X, Y and
// heading change, the last three each started by a launch step), a
// bit-serial divide by 360 for the CORDIC angle, the CORDIC micro-rotations
// and the turn reduction, then raises out_valid. When the receiver does not
// stall, the block returns to idle and takes the next input there.
// A clear command raises out_valid in the cycle after its transfer.
// Reset (rst, synchronous) zeroes the pose and loads the default registers.
// While the receiver stalls the result holds and no new item is taken.
// The user must write registers via cfg_we/cfg_index/cfg_data only while
// idle; the block itself does not enforce this.
module differential_drive_odometry import ddo_pkg::*; #(
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [23:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic cmd,
  input  logic [COUNT_WIDTH-1:0] left_count,
  input  logic [COUNT_WIDTH-1:0] right_count,
  input  logic left_dir,
  input  logic right_dir,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [24:0] heading
);
  localparam int MW = COUNT_WIDTH + 24;  // magnitude of one wheel distance
  localparam int SW = MW + 2;            // signed sum / diff
  localparam int AW = SW;
  localparam int BW = 34;
  localparam int PW = AW + BW;
  localparam int RW = (SW > 41) ? SW : 41;
  localparam int RK = SW - 25;           // turn reduction steps
  localparam int TW = SW + 2;
  localparam int SC = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam logic signed [TW-1:0] POS_MAX = TW'(32'sh7fff_ffff);
  localparam logic signed [TW-1:0] POS_MIN = TW'(32'sh8000_0000);

  state_t state, state_next;
  logic [23:0] pulse_distance, turn_gain;
  logic signed [31:0] xp, yp;
  logic [24:0] hp;
  logic [COUNT_WIDTH-1:0] rc;
  logic ld, rd;
  logic signed [SW-1:0] dl, dr;
  logic [2:0] phase;
  logic [5:0] cnt;
  logic signed [33:0] cx, cy;
  logic signed [33:0] cz;
  logic flip;
  logic [RW-1:0] rem;
  logic [31:0] quo;

  logic            m_start, m_done;
  logic [AW-1:0]   m_a;
  logic [BW-1:0]   m_b;
  logic [PW-1:0]   m_p;

  ddo_serial_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk(clk), .rst(rst), .start(m_start), .a(m_a), .b(m_b),
    .done(m_done), .prod(m_p)
  );

  logic signed [SW-1:0] sum, diff;
  assign sum  = dr + dl;
  assign diff = dr - dl;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid && !in_stall) state_next = cmd ? ST_DONE : ST_MUL;
      ST_MUL:    if (m_done && phase == 3'd1) state_next = ST_ANGLE;
      ST_ANGLE:  if (cnt == 6'd41) state_next = ST_CORDIC;
      ST_CORDIC: if (cnt == 6'(SC)) state_next = ST_PROD;
      ST_PROD:   if (m_done && phase == 3'd4) state_next = ST_WRAP;
      ST_WRAP:   if (cnt == 6'(RK)) state_next = ST_DONE;
      ST_DONE:   if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_DONE);
  end

  // multiplier operand select
  logic signed [SW-1:0] sel;
  logic signed [33:0] selb;
  always_comb begin
    sel  = sum;
    selb = cx;
    case (phase)
      3'd0: begin sel = '0; selb = '0; end
      3'd3: selb = cy;
      3'd4: begin sel = diff; selb = 34'(turn_gain); end
      default: ;
    endcase
  end
  logic [SW-1:0] selmag;
  logic [33:0] selbmag;
  assign selmag  = sel[SW-1] ? SW'(-sel) : SW'(sel);
  assign selbmag = selb[33] ? 34'(-selb) : 34'(selb);

  // rounding of the finished product
  logic [PW-1:0] rnd39, rnd24;
  assign rnd39 = (m_p + (PW'(1) << 38)) >> 39;
  assign rnd24 = (m_p + (PW'(1) << 23)) >> 24;
  logic signed [SW-1:0] delta;
  logic neg;
  logic signed [33:0] shx, shy;
  assign neg = sel[SW-1] ^ selb[33];
  assign delta = neg ? -SW'(rnd39) : SW'(rnd39);
  assign shx = cx >>> cnt[4:0];
  assign shy = cy >>> cnt[4:0];

  // position update with saturation
  logic signed [TW-1:0] tsum;
  logic signed [31:0] sat_pos;
  always_comb begin
    tsum = TW'(phase == 3'd2 ? xp : yp) + TW'(delta);
    if (tsum > POS_MAX) sat_pos = 32'sh7fff_ffff;
    else if (tsum < POS_MIN) sat_pos = 32'sh8000_0000;
    else sat_pos = tsum[31:0];
  end

  logic [RW-1:0] dstep, tstep;
  assign dstep = RW'(360) << (5'd31 - cnt[4:0]);
  assign tstep = RW'(FULL_TURN) << (6'(RK - 1) - cnt);

  // heading plus or minus a change already below a full turn
  logic [25:0] hadd;
  logic [24:0] hnew;
  assign hadd = {1'b0, hp} + {1'b0, rem[24:0]};
  always_comb begin
    if (!neg)
      hnew = (hadd >= {1'b0, FULL_TURN}) ? 25'(hadd - {1'b0, FULL_TURN}) : hadd[24:0];
    else
      hnew = (hp >= rem[24:0]) ? hp - rem[24:0] : hp + FULL_TURN - rem[24:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pulse_distance <= 24'd96609;
      turn_gain <= 24'd110444;
      xp <= '0; yp <= '0; hp <= '0;
      m_start <= 1'b0;
      phase <= '0;
      cnt <= '0;
    end else begin
      state <= state_next;
      m_start <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_PULSE_DISTANCE) pulse_distance <= cfg_data;
        else turn_gain <= cfg_data;
      end
      unique case (state)
        ST_IDLE: if (in_valid) begin
          if (cmd) begin
            xp <= '0; yp <= '0; hp <= '0;
          end else begin
            rc <= right_count; ld <= left_dir; rd <= right_dir;
            m_a <= AW'(left_count); m_b <= BW'(pulse_distance);
            m_start <= 1'b1; phase <= 3'd0;
          end
        end
        ST_MUL: if (m_done) begin
          if (phase == 3'd0) begin
            dl <= ld ? SW'(m_p[MW-1:0]) : -SW'(m_p[MW-1:0]);
            m_a <= AW'(rc); m_start <= 1'b1; phase <= 3'd1;
          end else begin
            dr <= rd ? SW'(m_p[MW-1:0]) : -SW'(m_p[MW-1:0]);
            rem <= RW'({hp, 16'd0}) + RW'(180); quo <= '0; cnt <= '0;
          end
        end
        ST_ANGLE: begin
          // restoring divide by 360, one quotient bit per cycle
          if (cnt < 6'd32) begin
            if (rem >= dstep) begin
              rem <= rem - dstep;
              quo <= quo | (32'd1 << (5'd31 - cnt[4:0]));
            end
            cnt <= cnt + 1'b1;
          end else if (cnt < 6'd41) begin
            cnt <= (cnt == 6'd32) ? 6'd41 : cnt + 1'b1;
            if (cnt == 6'd32) begin
              if ($signed(quo) > 32'sd1073741824 || $signed(quo) < -32'sd1073741824) begin
                flip <= 1'b1; cz <= 34'($signed(quo ^ 32'h8000_0000));
              end else begin
                flip <= 1'b0; cz <= 34'($signed(quo));
              end
              cx <= INV_GAIN_Q30; cy <= '0;
            end
          end else cnt <= '0;
        end
        ST_CORDIC: if (cnt < 6'(SC)) begin
          if (!cz[33]) begin
            cx <= cx - shy; cy <= cy + shx; cz <= cz - 34'(atan_lut(cnt[4:0]));
          end else begin
            cx <= cx + shy; cy <= cy - shx; cz <= cz + 34'(atan_lut(cnt[4:0]));
          end
          cnt <= cnt + 1'b1;
        end else begin
          if (flip) begin cx <= -cx; cy <= -cy; end
          phase <= 3'd2;
        end
        ST_PROD: begin
          // cnt == SC marks a launch cycle for the product of this phase
          if (cnt == 6'(SC)) begin
            m_a <= selmag; m_b <= selbmag; m_start <= 1'b1; cnt <= '0;
          end else if (m_done) begin
            if (phase == 3'd4) begin
              rem <= RW'(rnd24);
              cnt <= '0;
            end else begin
              if (phase == 3'd2) xp <= sat_pos; else yp <= sat_pos;
              phase <= phase + 1'b1;
              cnt <= 6'(SC);
            end
          end
        end
        ST_WRAP: begin
          // reduce the heading change mod a full turn, one shifted turn per cycle
          if (cnt < 6'(RK)) begin
            if (rem >= tstep) rem <= rem - tstep;
            cnt <= cnt + 1'b1;
          end else begin
            hp <= hnew;
            cnt <= '0;
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  assign pos_x = xp;
  assign pos_y = yp;
  assign heading = hp;

  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> heading < FULL_TURN)
    else $error("heading not wrapped");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(pos_x) && $stable(heading))
    else $error("result lost under stall");
endmodule
